FILE: design/trilinear_grid_gather_macros.svh
// Assertion macros for the trilinear grid gather block.
// Expects clk and rst to be visible where a macro is used.
`ifndef TRILINEAR_GRID_GATHER_MACROS_SVH
`define TRILINEAR_GRID_GATHER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tgg_pkg.sv
// Shared types and constants for the trilinear grid gather block.
// No dependencies; used by tgg_lerp, trilinear_grid_gather and tb.
`timescale 1ns / 1ps
`default_nettype none

package tgg_pkg;

  // Command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SCALAR = 2'd1;
  localparam logic [1:0] CMD_VECTOR = 2'd2;

  // Last vector component index
  localparam logic [1:0] COMP_Z = 2'd2;

  // Output queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int PTR_W    = $clog2(OQ_DEPTH);
  localparam int CNT_W    = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Per-component info carried alongside the data path
  typedef struct packed {
    logic [15:0] frac_x;
    logic [15:0] frac_y;
    logic [15:0] frac_z;
    logic [1:0]  component;
    logic        last;
    logic        error;
  } meta_t;

  // Tag through one lerp unit: idx tells which partial result this is
  typedef struct packed {
    meta_t      meta;
    logic [1:0] idx;
  } lerp_tag_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         component;
    logic               last;
    logic               error;
  } rsp_entry_t;

endpackage

`default_nettype wire

FILE: design/tgg_req_if.sv
// Request channel: valid/ready handshake with write and query fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tgg_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         field_sel;
  logic [2:0]         node_x;
  logic [2:0]         node_y;
  logic [2:0]         node_z;
  logic [15:0]        frac_x;
  logic [15:0]        frac_y;
  logic [15:0]        frac_z;
  logic signed [31:0] write_value;

  modport source (
    output valid, command, field_sel, node_x, node_y, node_z,
           frac_x, frac_y, frac_z, write_value,
    input  ready
  );

  modport sink (
    input  valid, command, field_sel, node_x, node_y, node_z,
           frac_x, frac_y, frac_z, write_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/tgg_rsp_if.sv
// Response channel: valid/ready handshake with one interpolated result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tgg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         component;
  logic               last;
  logic               error;

  modport source (
    output valid, value, component, last, error,
    input  ready
  );

  modport sink (
    input  valid, value, component, last, error,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/tgg_lerp.sv
// Two-stage Q16.16 linear blend a + (b - a) * f with round and saturate.
// Depends on tgg_pkg for the tag type.
`timescale 1ns / 1ps
`default_nettype none

module tgg_lerp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic [15:0]        frac,
  input  wire tgg_pkg::lerp_tag_t in_tag,
  output logic                    out_valid,
  output logic signed [31:0]      out_value,
  output tgg_pkg::lerp_tag_t      out_tag
);

  logic signed [32:0] diff;
  logic signed [16:0] frac_s;

  logic                     v1;
  logic signed [31:0]       a1;
  logic signed [49:0]       prod1;
  tgg_pkg::lerp_tag_t       tag1;

  logic signed [51:0] acc;
  logic signed [31:0] sat;

  // a*(1-f) + b*f rewritten as a*65536 + (b-a)*f
  assign diff   = {b[31], b} - {a[31], a};
  assign frac_s = {1'b0, frac};

  // Stage 1: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    a1    <= a;
    prod1 <= diff * frac_s;
    tag1  <= in_tag;
  end

  // Round half up, floor shift by 16, clamp to 32 bits
  assign acc = {{4{a1[31]}}, a1, 16'h0000} + {{2{prod1[49]}}, prod1} + 52'sd32768;

  always_comb begin
    if (acc[51:47] == 5'b00000 || acc[51:47] == 5'b11111) begin
      sat = acc[47:16];
    end else if (acc[51]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    out_value <= sat;
    out_tag   <= tag1;
  end

endmodule

`default_nettype wire

FILE: design/trilinear_grid_gather.sv
// Top level of the trilinear grid gather: node memory, read sequencer,
// x/y/z lerp units and output queue. Depends on tgg_pkg, tgg_req_if,
// tgg_rsp_if, tgg_lerp and trilinear_grid_gather_macros.svh.
//
//   channel | dir | beat carries
//   --------+-----+------------------------------------------------------
//   req     | in  | command, field_sel, node_x/y/z, frac_x/y/z, write_value
//   rsp     | out | value, component, last, error
//
// A query reads one corner per cycle from the single-port node memory once
// its component has started; a vector query blends three fields in turn.
// Reset clears control only; node memory stays undefined until written.
// A 4-entry output queue absorbs rsp stalls; a component starts only when
// a queue slot is reserved for it, so the data path never stalls.
`timescale 1ns / 1ps
`default_nettype none

module trilinear_grid_gather #(
  parameter int NODES_X    = 8,
  parameter int NODES_Y    = 8,
  parameter int NODES_Z    = 8,
  parameter int NUM_FIELDS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  tgg_req_if.sink   req,
  tgg_rsp_if.source rsp
);

`include "trilinear_grid_gather_macros.svh"

  localparam int NODES_PER_FIELD = NODES_X * NODES_Y * NODES_Z;
  localparam int DEPTH           = NUM_FIELDS * NODES_PER_FIELD;
  localparam int AW              = $clog2(DEPTH);

  localparam logic [AW-1:0] NX_W     = AW'(NODES_X);
  localparam logic [AW-1:0] NY_W     = AW'(NODES_Y);
  localparam logic [AW-1:0] NZ_W     = AW'(NODES_Z);
  localparam logic [AW-1:0] STRIDE_X = AW'(NODES_Y * NODES_Z);
  localparam logic [AW-1:0] STRIDE_Y = AW'(NODES_Z);
  localparam logic [AW-1:0] STRIDE_F = AW'(NODES_PER_FIELD);

  localparam logic [6:0] LIM_X = 7'(NODES_X);
  localparam logic [6:0] LIM_Y = 7'(NODES_Y);
  localparam logic [6:0] LIM_Z = 7'(NODES_Z);
  localparam logic [6:0] LIM_F = 7'(NUM_FIELDS);

  // ---------------------------------------------------------------------
  // Request decode
  logic          node_ok;
  logic          corner_ok;
  logic          write_ok;
  logic          scalar_ok;
  logic          vector_ok;
  logic [AW-1:0] base_in;

  assign node_ok   = (7'(req.node_x) < LIM_X) && (7'(req.node_y) < LIM_Y) &&
                     (7'(req.node_z) < LIM_Z);
  assign corner_ok = (7'(req.node_x) + 7'd1 < LIM_X) &&
                     (7'(req.node_y) + 7'd1 < LIM_Y) &&
                     (7'(req.node_z) + 7'd1 < LIM_Z);
  assign write_ok  = (7'(req.field_sel) < LIM_F) && node_ok;
  assign scalar_ok = (7'(req.field_sel) < LIM_F) && corner_ok;
  assign vector_ok = (7'(req.field_sel) + 7'd2 < LIM_F) && corner_ok;
  assign base_in   = ((AW'(req.field_sel) * NX_W + AW'(req.node_x)) * NY_W +
                      AW'(req.node_y)) * NZ_W + AW'(req.node_z);

  // ---------------------------------------------------------------------
  // Sequencer registers
  tgg_pkg::seq_state_t state, state_next;
  logic [1:0]          op;
  logic [AW-1:0]       addr;
  logic [15:0]         fx, fy, fz;
  logic                err;
  logic                wr_ok;
  logic [31:0]         wdata;
  logic [1:0]          comp;
  logic [1:0]          comp_last;
  logic [2:0]          cnt;

  logic                       is_query;
  logic                       credit_ok;
  logic                       step_go;
  logic                       final_step;
  logic                       accept;
  logic                       reserve;
  logic                       pop;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              corner_off;
  logic [AW-1:0]              mem_addr;
  logic [tgg_pkg::CNT_W-1:0]  credits;

  assign is_query  = (op == tgg_pkg::CMD_SCALAR) || (op == tgg_pkg::CMD_VECTOR);
  assign credit_ok = credits < tgg_pkg::CNT_W'(tgg_pkg::OQ_DEPTH);

  // A query component may start only with a reserved queue slot
  always_comb begin
    step_go    = (state == tgg_pkg::SEQ_RUN) && (!is_query || cnt != 3'd0 || credit_ok);
    final_step = step_go && (!is_query || (cnt == 3'd7 && comp == comp_last));
    req.ready  = (state == tgg_pkg::SEQ_IDLE) || final_step;
    accept     = req.valid && req.ready;
    reserve    = step_go && is_query && cnt == 3'd0;
    state_next = state;
    case (state)
      tgg_pkg::SEQ_IDLE: begin
        if (accept) state_next = tgg_pkg::SEQ_RUN;
      end
      tgg_pkg::SEQ_RUN: begin
        if (final_step && !accept) state_next = tgg_pkg::SEQ_IDLE;
      end
      default: state_next = tgg_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgg_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item load on accept, corner and component stepping otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= tgg_pkg::CMD_WRITE;
      cnt       <= 3'd0;
      comp      <= 2'd0;
      comp_last <= 2'd0;
    end else if (accept) begin
      op        <= req.command;
      cnt       <= 3'd0;
      comp      <= 2'd0;
      comp_last <= (req.command == tgg_pkg::CMD_VECTOR) ? tgg_pkg::COMP_Z : 2'd0;
    end else if (step_go && is_query) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) comp <= comp + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr  <= base_in;
      fx    <= req.frac_x;
      fy    <= req.frac_y;
      fz    <= req.frac_z;
      err   <= (req.command == tgg_pkg::CMD_VECTOR) ? !vector_ok : !scalar_ok;
      wr_ok <= write_ok;
      wdata <= req.write_value;
    end else if (step_go && is_query && cnt == 3'd7) begin
      addr <= addr + STRIDE_F;
    end
  end

  // ---------------------------------------------------------------------
  // Node memory: one access per cycle, corner order x fastest, then y, z
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  assign corner_off = (cnt[0] ? STRIDE_X : '0) + (cnt[1] ? STRIDE_Y : '0) +
                      (cnt[2] ? AW'(1) : '0);
  assign mem_addr   = addr + corner_off;
  assign mem_we     = step_go && op == tgg_pkg::CMD_WRITE && wr_ok;
  assign mem_re     = step_go && is_query && !err;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  // Token that lines up with the read data
  logic           s1_valid;
  logic [2:0]     s1_corner;
  tgg_pkg::meta_t s1_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= step_go && is_query;
    end
    s1_corner <= cnt;
    s1_meta   <= '{frac_x: fx, frac_y: fy, frac_z: fz, component: comp,
                   last: comp == comp_last, error: err};
  end

  // ---------------------------------------------------------------------
  // X lerps: pair each even corner with the odd one after it
  logic signed [31:0] xa_hold;
  logic               x_in_vld;
  tgg_pkg::lerp_tag_t x_in_tag;
  logic               x_vld;
  logic signed [31:0] x_val;
  tgg_pkg::lerp_tag_t x_tag;

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_corner[0]) xa_hold <= $signed(rdata);
  end

  assign x_in_vld = s1_valid && s1_corner[0];
  assign x_in_tag = '{meta: s1_meta, idx: s1_corner[2:1]};

  tgg_lerp u_lerp_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x_in_vld),
    .a         (xa_hold),
    .b         ($signed(rdata)),
    .frac      (s1_meta.frac_x),
    .in_tag    (x_in_tag),
    .out_valid (x_vld),
    .out_value (x_val),
    .out_tag   (x_tag)
  );

  // Y lerps: (y,z) with (y+1,z), then (y,z+1) with (y+1,z+1)
  logic signed [31:0] ya_hold;
  logic               y_in_vld;
  tgg_pkg::lerp_tag_t y_in_tag;
  logic               y_vld;
  logic signed [31:0] y_val;
  tgg_pkg::lerp_tag_t y_tag;

  always_ff @(posedge clk) begin
    if (x_vld && !x_tag.idx[0]) ya_hold <= x_val;
  end

  assign y_in_vld = x_vld && x_tag.idx[0];
  assign y_in_tag = '{meta: x_tag.meta, idx: {1'b0, x_tag.idx[1]}};

  tgg_lerp u_lerp_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (y_in_vld),
    .a         (ya_hold),
    .b         (x_val),
    .frac      (x_tag.meta.frac_y),
    .in_tag    (y_in_tag),
    .out_valid (y_vld),
    .out_value (y_val),
    .out_tag   (y_tag)
  );

  // Z lerp: z plane with z+1 plane
  logic signed [31:0] za_hold;
  logic               z_in_vld;
  tgg_pkg::lerp_tag_t z_in_tag;
  logic               z_vld;
  logic signed [31:0] z_val;
  tgg_pkg::lerp_tag_t z_tag;

  always_ff @(posedge clk) begin
    if (y_vld && !y_tag.idx[0]) za_hold <= y_val;
  end

  assign z_in_vld = y_vld && y_tag.idx[0];
  assign z_in_tag = '{meta: y_tag.meta, idx: 2'd0};

  tgg_lerp u_lerp_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (z_in_vld),
    .a         (za_hold),
    .b         (y_val),
    .frac      (y_tag.meta.frac_z),
    .in_tag    (z_in_tag),
    .out_valid (z_vld),
    .out_value (z_val),
    .out_tag   (z_tag)
  );

  // ---------------------------------------------------------------------
  // Output queue with slot reservation
  tgg_pkg::rsp_entry_t        oq [tgg_pkg::OQ_DEPTH];
  tgg_pkg::rsp_entry_t        push_entry;
  logic [tgg_pkg::PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [tgg_pkg::CNT_W-1:0]  count;

  assign push_entry = '{value: z_tag.meta.error ? 32'sd0 : z_val,
                        component: z_tag.meta.component,
                        last: z_tag.meta.last,
                        error: z_tag.meta.error};
  assign pop = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (z_vld) oq[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      credits <= '0;
    end else begin
      if (z_vld) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count   <= count + tgg_pkg::CNT_W'(z_vld) - tgg_pkg::CNT_W'(pop);
      credits <= credits + tgg_pkg::CNT_W'(reserve) - tgg_pkg::CNT_W'(pop);
    end
  end

  assign rsp.valid     = count != '0;
  assign rsp.value     = oq[rd_ptr].value;
  assign rsp.component = oq[rd_ptr].component;
  assign rsp.last      = oq[rd_ptr].last;
  assign rsp.error     = oq[rd_ptr].error;

  // ---------------------------------------------------------------------
  // Assertions
  `ASSERT_IMPLIES(a_oq_no_overflow, z_vld, count < tgg_pkg::CNT_W'(tgg_pkg::OQ_DEPTH), "queue push while full")
  `ASSERT_IMPLIES(a_count_in_credit, 1'b1, count <= credits, "queue holds more than reserved")
  `ASSERT_IMPLIES(a_err_is_zero, rsp.valid && rsp.error, rsp.value == 32'sd0, "error beat with nonzero value")
  `ASSERT_NEXT(a_reserve_counts, reserve && !pop, credits == $past(credits) + tgg_pkg::CNT_W'(1), "reservation lost")

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for trilinear_grid_gather: a directed table, then random
// write/query traffic scored against an in-bench Q16.16 trilinear predictor.
// Depends on tgg_pkg, tgg_req_if, tgg_rsp_if and the design sources.

module tb;

  localparam int GRID_N       = 8;
  localparam int FIELDS       = 8;
  localparam int DEPTH        = FIELDS * GRID_N * GRID_N * GRID_N;
  localparam int RANDOM_ITEMS = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;
  localparam int NUM_DIR      = 24;

  // Command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  fld;
    logic [2:0]  nx;
    logic [2:0]  ny;
    logic [2:0]  nz;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] fz;
    logic [31:0] wval;
  } req_beat_t;

  // typed = 1: expected value/error written in the row, not predicted
  typedef struct packed {
    req_beat_t   beat;
    logic        typed;
    logic [31:0] tval;
    logic        terr;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // corners off the grid
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd7, 3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0},
      1'b1, 32'h0, 1'b1},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd7, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0},
      1'b1, 32'h0, 1'b1},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0},
      1'b1, 32'h0, 1'b1},
    // vector field range runs past the last field, or a corner off the grid
    '{'{tgg_pkg::CMD_VECTOR, 3'd6, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0},
      1'b1, 32'h0, 1'b1},
    '{'{tgg_pkg::CMD_VECTOR, 3'd7, 3'd7, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        32'hFFFF_FFFF},
      1'b1, 32'h0, 1'b1},
    '{'{tgg_pkg::CMD_VECTOR, 3'd5, 3'd0, 3'd0, 3'd7, 16'h8000, 16'h8000, 16'h8000, 32'h0},
      1'b1, 32'h0, 1'b1},
    // ignored command
    '{'{CMD_UNUSED, 3'd7, 3'd7, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF},
      1'b0, 32'h0, 1'b0},
    // fill cell (0,0,0) of field 0 with extremes
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd1, 3'd0, 3'd0, 16'h0, 16'h0, 16'h0, 32'h8000_0000},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd0, 3'd1, 3'd0, 16'h0, 16'h0, 16'h0, 32'h0000_0000},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd1, 3'd1, 3'd0, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd0, 3'd0, 3'd1, 16'h0, 16'h0, 16'h0, 32'h0001_0000},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd1, 3'd0, 3'd1, 16'h0, 16'h0, 16'h0, 32'hFFFF_0000},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd0, 3'd1, 3'd1, 16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd1, 3'd1, 3'd1, 16'h0, 16'h0, 16'h0, 32'h8000_0000},
      1'b0, 32'h0, 1'b0},
    // zero offsets return the lower corner as is, then nonzero offsets
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0},
      1'b1, 32'h7FFF_FFFF, 1'b0},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'hFFFF, 16'h0000, 16'h0000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'h8000, 16'h8000, 16'h8000, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0000, 16'hFFFF, 32'h0},
      1'b0, 32'h0, 1'b0},
    // top node of the last field, then overwrite of a corner and queries of the cell
    '{'{tgg_pkg::CMD_WRITE, 3'd7, 3'd7, 3'd7, 3'd7, 16'h0, 16'h0, 16'h0, 32'h1234_5678},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_WRITE, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0, 16'h0, 16'h0, 32'h8000_0000},
      1'b0, 32'h0, 1'b0},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0},
      1'b1, 32'h8000_0000, 1'b0},
    '{'{tgg_pkg::CMD_SCALAR, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0001, 16'hFFFE, 16'h4000, 32'h0},
      1'b0, 32'h0, 1'b0}
  };

  logic clk;
  logic rst;

  tgg_req_if req ();
  tgg_rsp_if rsp ();

  trilinear_grid_gather #(
    .NODES_X   (GRID_N),
    .NODES_Y   (GRID_N),
    .NODES_Z   (GRID_N),
    .NUM_FIELDS(FIELDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Predictor state: node values, which nodes hold data, results in flight
  logic signed [31:0]  node_mem [DEPTH];
  bit                  node_written [DEPTH];
  tgg_pkg::rsp_entry_t pending_results [$];
  int                  fail_count;
  bit                  no_gaps;

  function automatic int node_index(int f, int x, int y, int z);
    return ((f * GRID_N + x) * GRID_N + y) * GRID_N + z;
  endfunction

  // One Q16.16 lerp: wide weighted sum, round half up by floor shift, saturate
  function automatic logic signed [31:0] lerp_q16(logic signed [31:0] lo,
                                                  logic signed [31:0] hi,
                                                  logic [15:0] frac);
    longint acc;
    acc = longint'(lo) * (longint'(65536) - longint'(frac)) + longint'(hi) * longint'(frac);
    acc = (acc + 64'sd32768) >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    else if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  // Trilinear blend of one cell: x lerps first, then y, then z
  function automatic logic signed [31:0] blend_cell(int f, int x, int y, int z,
                                                    logic [15:0] fx, logic [15:0] fy,
                                                    logic [15:0] fz);
    logic signed [31:0] along_x [2][2];
    logic signed [31:0] along_y [2];
    for (int dy = 0; dy < 2; dy++) begin
      for (int dz = 0; dz < 2; dz++) begin
        along_x[dy][dz] = lerp_q16(node_mem[node_index(f, x, y + dy, z + dz)],
                                   node_mem[node_index(f, x + 1, y + dy, z + dz)], fx);
      end
    end
    for (int dz = 0; dz < 2; dz++) begin
      along_y[dz] = lerp_q16(along_x[0][dz], along_x[1][dz], fy);
    end
    return lerp_q16(along_y[0], along_y[1], fz);
  endfunction

  // Apply an accepted beat to the predictor and queue what it should produce
  function automatic void predict_beat(req_beat_t b);
    tgg_pkg::rsp_entry_t r;
    bit                  corner_ok;
    bit                  fields_ok;
    int                  idx;
    corner_ok = (int'(b.nx) + 1 < GRID_N) && (int'(b.ny) + 1 < GRID_N) &&
                (int'(b.nz) + 1 < GRID_N);
    case (b.cmd)
      tgg_pkg::CMD_WRITE: begin
        if (int'(b.fld) < FIELDS && int'(b.nx) < GRID_N && int'(b.ny) < GRID_N &&
            int'(b.nz) < GRID_N) begin
          idx = node_index(b.fld, b.nx, b.ny, b.nz);
          node_mem[idx]     = b.wval;
          node_written[idx] = 1'b1;
        end
      end
      tgg_pkg::CMD_SCALAR: begin
        fields_ok   = int'(b.fld) < FIELDS;
        r.component = 2'd0;
        r.last      = 1'b1;
        r.error     = !(fields_ok && corner_ok);
        r.value     = r.error ? 32'sd0 :
                      blend_cell(b.fld, b.nx, b.ny, b.nz, b.fx, b.fy, b.fz);
        pending_results.push_back(r);
      end
      tgg_pkg::CMD_VECTOR: begin
        fields_ok = int'(b.fld) + 2 < FIELDS;
        for (int k = 0; k < 3; k++) begin
          r.component = 2'(k);
          r.last      = (2'(k) == tgg_pkg::COMP_Z);
          r.error     = !(fields_ok && corner_ok);
          r.value     = r.error ? 32'sd0 :
                        blend_cell(int'(b.fld) + k, b.nx, b.ny, b.nz, b.fx, b.fy, b.fz);
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_node_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Lower corner index, mostly from a small region so cells get reused
  function automatic int pick_coord();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, GRID_N - 2) : $urandom_range(3, 4);
  endfunction

  // Drive one request beat and return at the edge where it is accepted
  task automatic drive_beat(req_beat_t b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.command     <= b.cmd;
    req.field_sel   <= b.fld;
    req.node_x      <= b.nx;
    req.node_y      <= b.ny;
    req.node_z      <= b.nz;
    req.frac_x      <= b.fx;
    req.frac_y      <= b.fy;
    req.frac_z      <= b.fz;
    req.write_value <= b.wval;
    req.valid       <= 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  function automatic void check_result(tgg_pkg::rsp_entry_t got);
    tgg_pkg::rsp_entry_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("unexpected result: value=%h comp=%0d last=%0b err=%0b",
                 got.value, got.component, got.last, got.error);
      return;
    end
    want = pending_results.pop_front();
    if (got.value !== want.value || got.component !== want.component ||
        got.last !== want.last || got.error !== want.error) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("result mismatch: expected value=%h comp=%0d last=%0b err=%0b, got value=%h comp=%0d last=%0b err=%0b",
                 want.value, want.component, want.last, want.error,
                 got.value, got.component, got.last, got.error);
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, score every accepted beat
  initial begin
    int                  stall;
    tgg_pkg::rsp_entry_t got;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.value     = rsp.value;
      got.component = rsp.component;
      got.last      = rsp.last;
      got.error     = rsp.error;
      check_result(got);
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Request side: reset, directed table, random traffic, drain
  initial begin
    req_beat_t           b;
    tgg_pkg::rsp_entry_t r;
    int                  random_items;
    int                  seq_count;
    int                  pick;
    int                  base;
    int                  last_fld;
    int                  cx;
    int                  cy;
    int                  cz;
    int                  idx;
    int                  n;
    bit                  vec;

    fail_count   = 0;
    no_gaps      = 1'b0;
    random_items = 0;
    seq_count    = 0;

    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.command     <= tgg_pkg::CMD_WRITE;
    req.field_sel   <= '0;
    req.node_x      <= '0;
    req.node_y      <= '0;
    req.node_z      <= '0;
    req.frac_x      <= '0;
    req.frac_y      <= '0;
    req.frac_z      <= '0;
    req.write_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      drive_beat(DIR_ROWS[i].beat);
      if (DIR_ROWS[i].typed) begin
        n = (DIR_ROWS[i].beat.cmd == tgg_pkg::CMD_VECTOR) ? 3 : 1;
        for (int k = 0; k < n; k++) begin
          r.value     = DIR_ROWS[i].tval;
          r.component = 2'(k);
          r.last      = (k == n - 1);
          r.error     = DIR_ROWS[i].terr;
          pending_results.push_back(r);
        end
      end else begin
        predict_beat(DIR_ROWS[i].beat);
      end
    end

    // Random traffic: mostly fill-then-query sequences, some noise
    while (random_items < RANDOM_ITEMS) begin
      if (seq_count % 12 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      seq_count++;
      pick   = $urandom_range(0, 99);
      b.fld  = 3'($urandom_range(0, 7));
      b.nx   = 3'($urandom_range(0, 7));
      b.ny   = 3'($urandom_range(0, 7));
      b.nz   = 3'($urandom_range(0, 7));
      b.fx   = rand_frac();
      b.fy   = rand_frac();
      b.fz   = rand_frac();
      b.wval = $urandom();
      if (pick < 8) begin
        // ignored command, random payload
        b.cmd = CMD_UNUSED;
        drive_beat(b);
        predict_beat(b);
      end else if (pick < 18) begin
        // query with a corner or field range off the grid
        b.cmd = $urandom_range(0, 1) ? tgg_pkg::CMD_SCALAR : tgg_pkg::CMD_VECTOR;
        case ($urandom_range(0, 3))
          0: b.nx = 3'(GRID_N - 1);
          1: b.ny = 3'(GRID_N - 1);
          2: b.nz = 3'(GRID_N - 1);
          default: begin
            if (b.cmd == tgg_pkg::CMD_VECTOR) b.fld = 3'($urandom_range(FIELDS - 2, FIELDS - 1));
            else b.nz = 3'(GRID_N - 1);
          end
        endcase
        drive_beat(b);
        predict_beat(b);
        random_items++;
      end else if (pick < 28) begin
        // lone write anywhere
        b.cmd  = tgg_pkg::CMD_WRITE;
        b.wval = rand_node_value();
        drive_beat(b);
        predict_beat(b);
        random_items++;
      end else begin
        // write any missing corners (plus an odd rewrite), then query the cell
        vec = ($urandom_range(0, 2) == 0);
        if (vec) base = ($urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, FIELDS - 3);
        else base = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 2) :
                                                  $urandom_range(0, FIELDS - 1);
        last_fld = vec ? base + 2 : base;
        cx = pick_coord();
        cy = pick_coord();
        cz = pick_coord();
        for (int f = base; f <= last_fld; f++) begin
          for (int c = 0; c < 8; c++) begin
            idx = node_index(f, cx + (c & 1), cy + ((c >> 1) & 1), cz + ((c >> 2) & 1));
            if (!node_written[idx] || $urandom_range(0, 15) == 0) begin
              b.cmd  = tgg_pkg::CMD_WRITE;
              b.fld  = 3'(f);
              b.nx   = 3'(cx + (c & 1));
              b.ny   = 3'(cy + ((c >> 1) & 1));
              b.nz   = 3'(cz + ((c >> 2) & 1));
              b.wval = rand_node_value();
              drive_beat(b);
              predict_beat(b);
              random_items++;
            end
          end
        end
        b.cmd = vec ? tgg_pkg::CMD_VECTOR : tgg_pkg::CMD_SCALAR;
        b.fld = 3'(base);
        b.nx  = 3'(cx);
        b.ny  = 3'(cy);
        b.nz  = 3'(cz);
        b.fx  = rand_frac();
        b.fy  = rand_frac();
        b.fz  = rand_frac();
        drive_beat(b);
        predict_beat(b);
        random_items++;
      end
    end
    req.valid <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/tgg_pkg.sv
design/tgg_req_if.sv
design/tgg_rsp_if.sv
design/tgg_lerp.sv
design/trilinear_grid_gather.sv
verif/tb.sv
